[rtl/srf_pkg.sv]
package srf_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIAS_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_TIME  = 3'd4;

    // reset values of the configuration registers
    localparam logic [15:0] RST_LOCAL_ADDR = 16'd1;
    localparam logic [15:0] RST_BCAST_ADDR = 16'hFFFF;
    localparam logic [15:0] RST_ALIAS_ADDR = 16'hFFFE;
    localparam logic [7:0]  RST_MAX_HOPS   = 8'd16;
    localparam logic [30:0] RST_VALID_TIME = 31'd32768;

    typedef enum logic [1:0] {
        ACT_INFO      = 2'd0,
        ACT_PACKET    = 2'd1,
        ACT_FRAME_END = 2'd2,
        ACT_BEACON    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DEC_LOCAL   = 2'd0,
        DEC_BCAST   = 2'd1,
        DEC_UNICAST = 2'd2,
        DEC_DROP    = 2'd3
    } decision_t;

    typedef enum logic [1:0] {
        BCN_NONE    = 2'd0,
        BCN_REQUEST = 2'd1,
        BCN_INFO    = 2'd2
    } beacon_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now;
        logic [15:0] info_seqnum;
        logic [7:0]  info_hops;
        logic [15:0] info_root;
        logic [15:0] sender_addr;
        logic        from_self;
        logic [15:0] dst_addr;
        logic [7:0]  hop_limit_in;
    } srf_item_t;

    typedef struct packed {
        decision_t   decision;
        logic [15:0] next_hop;
        logic        next_hop_known;
        logic [15:0] dst_out;
        logic [7:0]  hop_limit_out;
        logic        info_updated;
        beacon_t     beacon_kind;
        logic [7:0]  beacon_hops;
        logic [15:0] beacon_seqnum;
        logic [15:0] beacon_root;
        logic        route_valid;
    } srf_result_t;

endpackage

[rtl/srf_in_stage.sv]
module srf_in_stage
    import srf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  srf_item_t s_item,
    input  logic      advance,
    output logic      item_valid,
    output srf_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    srf_item_t item_reg;

    // the held word moves on whenever the result side can take it
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/srf_core.sv]
module srf_core
    import srf_pkg::*;
#(
    parameter int unsigned ADDR_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  fire,
    input  srf_item_t             item,
    output srf_result_t           result
);

    localparam int unsigned AW = ADDR_WIDTH;

    // configuration
    logic [AW-1:0] local_addr_reg;
    logic [AW-1:0] bcast_addr_reg;
    logic [AW-1:0] alias_addr_reg;
    logic [7:0]    max_hops_reg;
    logic [30:0]   valid_time_reg;

    // route state
    logic [AW-1:0] root_addr_reg,   root_addr_next;
    logic [AW-1:0] hop_next_reg,    hop_next_next;
    logic [15:0]   seen_seqnum_reg, seen_seqnum_next;
    logic [7:0]    hops_reg,        hops_next;
    logic [31:0]   last_time_reg,   last_time_next;
    logic          seen_frame_reg,  seen_frame_next;

    // address conversion between 16-bit fields and the stored width
    logic [63:0]   cfg_addr_ext;
    logic [63:0]   info_root_ext;
    logic [63:0]   sender_ext;
    logic [63:0]   dst_ext;
    logic [AW-1:0] cfg_addr_val;
    logic [AW-1:0] iroot;
    logic [AW-1:0] sender;
    logic [AW-1:0] dst_in;

    assign cfg_addr_ext  = 64'(cfg_wdata[15:0]);
    assign info_root_ext = 64'(item.info_root);
    assign sender_ext    = 64'(item.sender_addr);
    assign dst_ext       = 64'(item.dst_addr);
    assign cfg_addr_val  = cfg_addr_ext[AW-1:0];
    assign iroot         = info_root_ext[AW-1:0];
    assign sender        = sender_ext[AW-1:0];
    assign dst_in        = dst_ext[AW-1:0];

    // route validity: hops below max and deadline not passed (serial time)
    logic [31:0] deadline_diff;
    logic        hops_ok;
    logic        expired;
    logic        chk;
    logic [7:0]  hops_chk;

    assign deadline_diff = last_time_reg + {1'b0, valid_time_reg} - item.now;
    assign expired       = deadline_diff[31];
    assign hops_ok       = hops_reg < max_hops_reg;
    assign chk           = hops_ok && !expired;
    assign hops_chk      = (hops_ok && expired) ? max_hops_reg : hops_reg;

    // routing info acceptance
    logic [15:0] seq_diff;
    logic        newer;
    logic        upd;

    assign seq_diff = seen_seqnum_reg - item.info_seqnum;
    assign newer    = seq_diff[15];

    always_comb begin
        upd = 1'b0;
        if (!chk || newer) begin
            upd = 1'b1;
        end else if (item.info_seqnum == seen_seqnum_reg) begin
            if (item.info_hops < hops_chk) begin
                upd = 1'b1;
            end else if (item.info_hops == hops_chk && !seen_frame_reg) begin
                upd = 1'b1;
            end
        end
        if (item.info_hops > max_hops_reg) begin
            upd = 1'b0;
        end
    end

    // packet routing
    logic          alias_hit;
    logic [AW-1:0] dst_sel;
    logic [7:0]    hl_sel;
    logic          hl_dec_en;
    logic [7:0]    hl_dec;
    logic          node_dst;
    logic          is_bcast_dst;
    logic          is_root_dst;
    logic [63:0]   dst_out_ext;
    logic [63:0]   hop_next_ext;
    logic [63:0]   root_ext;

    assign alias_hit    = item.from_self && (dst_in == alias_addr_reg);
    assign dst_sel      = alias_hit ? root_addr_reg : dst_in;
    assign hl_sel       = alias_hit ? max_hops_reg : item.hop_limit_in;
    assign hl_dec_en    = !item.from_self && (hl_sel != 8'd0);
    assign hl_dec       = hl_sel - 8'd1;
    assign node_dst     = dst_sel == local_addr_reg;
    assign is_bcast_dst = dst_sel == bcast_addr_reg;
    assign is_root_dst  = dst_sel == root_addr_reg;
    assign dst_out_ext  = 64'(dst_sel);
    assign hop_next_ext = 64'(hop_next_reg);
    assign root_ext     = 64'(root_addr_reg);

    always_comb begin
        result              = '0;
        result.decision     = DEC_DROP;
        result.beacon_kind  = BCN_NONE;
        result.route_valid  = chk;
        root_addr_next      = root_addr_reg;
        hop_next_next       = hop_next_reg;
        seen_seqnum_next    = seen_seqnum_reg;
        hops_next           = hops_chk;
        last_time_next      = last_time_reg;
        seen_frame_next     = seen_frame_reg;

        case (item.action)
            ACT_INFO: begin
                if (upd) begin
                    seen_frame_next     = 1'b1;
                    root_addr_next      = iroot;
                    hop_next_next       = sender;
                    seen_seqnum_next    = item.info_seqnum;
                    hops_next           = item.info_hops;
                    last_time_next      = item.now;
                    result.info_updated = 1'b1;
                    // fresh timestamp cannot have expired
                    result.route_valid  = item.info_hops < max_hops_reg;
                end
            end
            ACT_PACKET: begin
                result.dst_out       = dst_out_ext[15:0];
                result.hop_limit_out = hl_sel;
                if (node_dst) begin
                    result.decision = DEC_LOCAL;
                end else if (is_bcast_dst) begin
                    result.decision = item.from_self ? DEC_BCAST : DEC_LOCAL;
                end else begin
                    if (hl_dec_en) begin
                        result.hop_limit_out = hl_dec;
                    end
                    if (hl_dec_en && hl_dec == 8'd0) begin
                        result.decision = DEC_DROP;
                    end else if (is_root_dst) begin
                        if (chk) begin
                            result.next_hop       = hop_next_ext[15:0];
                            result.next_hop_known = 1'b1;
                            result.decision       = DEC_UNICAST;
                        end
                    end else if (item.from_self) begin
                        result.decision = DEC_UNICAST;
                    end
                end
            end
            ACT_FRAME_END: begin
                seen_frame_next = 1'b0;
            end
            ACT_BEACON: begin
                if (hops_ok) begin
                    if (expired) begin
                        result.beacon_kind = BCN_REQUEST;
                    end else begin
                        result.beacon_kind   = BCN_INFO;
                        result.beacon_hops   = hops_reg + 8'd1;
                        result.beacon_seqnum = seen_seqnum_reg;
                        result.beacon_root   = root_ext[15:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg <= AW'(RST_LOCAL_ADDR);
            bcast_addr_reg <= AW'(RST_BCAST_ADDR);
            alias_addr_reg <= AW'(RST_ALIAS_ADDR);
            max_hops_reg   <= RST_MAX_HOPS;
            valid_time_reg <= RST_VALID_TIME;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_LOCAL_ADDR: local_addr_reg <= cfg_addr_val;
                CFG_BCAST_ADDR: bcast_addr_reg <= cfg_addr_val;
                CFG_ALIAS_ADDR: alias_addr_reg <= cfg_addr_val;
                CFG_MAX_HOPS:   max_hops_reg   <= cfg_wdata[7:0];
                CFG_VALID_TIME: valid_time_reg <= cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_addr_reg   <= '0;
            hop_next_reg    <= '0;
            seen_seqnum_reg <= '0;
            hops_reg        <= RST_MAX_HOPS;
            last_time_reg   <= '0;
            seen_frame_reg  <= 1'b0;
        end else if (fire) begin
            root_addr_reg   <= root_addr_next;
            hop_next_reg    <= hop_next_next;
            seen_seqnum_reg <= seen_seqnum_next;
            hops_reg        <= hops_next;
            last_time_reg   <= last_time_next;
            seen_frame_reg  <= seen_frame_next;
        end
    end

endmodule

[rtl/srf_out_stage.sv]
module srf_out_stage
    import srf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  srf_result_t result,
    output logic        advance,
    output logic        m_valid,
    input  logic        m_ready,
    output srf_result_t m_result
);

    logic        valid_reg;
    logic        valid_next;
    srf_result_t result_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

[rtl/sink_route_forwarder.sv]
// path: a word accepted into the input register goes through the compute pass and is loaded
//   into the result register, which drives the result side
// throughput: one word per cycle unless m_ready stalls, set by the single compute pass
//   between the input and result registers; the route state is updated in that same pass
// reset: aresetn synchronous, active low; clears both stages, restores the register
//   defaults and leaves the route invalid (hop count at the maximum)
module sink_route_forwarder
    import srf_pkg::*;
#(
    parameter int unsigned ADDR_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [31:0]           s_now,
    input  logic [15:0]           s_info_seqnum,
    input  logic [7:0]            s_info_hops,
    input  logic [15:0]           s_info_root,
    input  logic [15:0]           s_sender_addr,
    input  logic                  s_from_self,
    input  logic [15:0]           s_dst_addr,
    input  logic [7:0]            s_hop_limit_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_decision,
    output logic [15:0]           m_next_hop,
    output logic                  m_next_hop_known,
    output logic [15:0]           m_dst_out,
    output logic [7:0]            m_hop_limit_out,
    output logic                  m_info_updated,
    output logic [1:0]            m_beacon_kind,
    output logic [7:0]            m_beacon_hops,
    output logic [15:0]           m_beacon_seqnum,
    output logic [15:0]           m_beacon_root,
    output logic                  m_route_valid
);

    srf_item_t   s_item;
    srf_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        fire;
    srf_result_t result;
    srf_result_t m_result;

    assign s_item.action       = s_action;
    assign s_item.now          = s_now;
    assign s_item.info_seqnum  = s_info_seqnum;
    assign s_item.info_hops    = s_info_hops;
    assign s_item.info_root    = s_info_root;
    assign s_item.sender_addr  = s_sender_addr;
    assign s_item.from_self    = s_from_self;
    assign s_item.dst_addr     = s_dst_addr;
    assign s_item.hop_limit_in = s_hop_limit_in;

    assign fire = item_valid && advance;

    srf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    srf_core #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    srf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .advance  (advance),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_decision       = m_result.decision;
    assign m_next_hop       = m_result.next_hop;
    assign m_next_hop_known = m_result.next_hop_known;
    assign m_dst_out        = m_result.dst_out;
    assign m_hop_limit_out  = m_result.hop_limit_out;
    assign m_info_updated   = m_result.info_updated;
    assign m_beacon_kind    = m_result.beacon_kind;
    assign m_beacon_hops    = m_result.beacon_hops;
    assign m_beacon_seqnum  = m_result.beacon_seqnum;
    assign m_beacon_root    = m_result.beacon_root;
    assign m_route_valid    = m_result.route_valid;

endmodule

[rtl/srf_checker.sv]
module srf_checker
    import srf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_decision,
    input logic                  m_next_hop_known,
    input logic [15:0]           m_dst_out,
    input logic                  m_info_updated,
    input logic [1:0]            m_beacon_kind,
    input logic                  m_route_valid
);

    // no word is left in the result register after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_decision) && $stable(m_dst_out))
        else $error("result word dropped or changed while stalled");

    // a known next hop is only given for a live route
    a_next_hop_route: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_next_hop_known |-> m_route_valid && m_decision == DEC_UNICAST)
        else $error("next hop given without a valid route");

    // advertised routing info implies the route was still live
    a_beacon_route: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beacon_kind == BCN_INFO |-> m_route_valid && m_decision == DEC_DROP)
        else $error("routing info advertised for an invalid route");

    // info and beacon words carry no packet decision
    a_non_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_info_updated || m_beacon_kind != BCN_NONE)
            |-> m_decision == DEC_DROP && !m_next_hop_known && m_dst_out == 16'd0)
        else $error("packet fields set on a non-packet word");

endmodule

bind sink_route_forwarder srf_checker u_srf_checker (.*);

[test/sink_route_forwarder_tb.sv]
module sink_route_forwarder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srf_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_action = '0;
    logic [31:0]           s_now = '0;
    logic [15:0]           s_info_seqnum = '0;
    logic [7:0]            s_info_hops = '0;
    logic [15:0]           s_info_root = '0;
    logic [15:0]           s_sender_addr = '0;
    logic                  s_from_self = 1'b0;
    logic [15:0]           s_dst_addr = '0;
    logic [7:0]            s_hop_limit_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_decision;
    logic [15:0]           m_next_hop;
    logic                  m_next_hop_known;
    logic [15:0]           m_dst_out;
    logic [7:0]            m_hop_limit_out;
    logic                  m_info_updated;
    logic [1:0]            m_beacon_kind;
    logic [7:0]            m_beacon_hops;
    logic [15:0]           m_beacon_seqnum;
    logic [15:0]           m_beacon_root;
    logic                  m_route_valid;

    sink_route_forwarder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_now            (s_now),
        .s_info_seqnum    (s_info_seqnum),
        .s_info_hops      (s_info_hops),
        .s_info_root      (s_info_root),
        .s_sender_addr    (s_sender_addr),
        .s_from_self      (s_from_self),
        .s_dst_addr       (s_dst_addr),
        .s_hop_limit_in   (s_hop_limit_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_decision       (m_decision),
        .m_next_hop       (m_next_hop),
        .m_next_hop_known (m_next_hop_known),
        .m_dst_out        (m_dst_out),
        .m_hop_limit_out  (m_hop_limit_out),
        .m_info_updated   (m_info_updated),
        .m_beacon_kind    (m_beacon_kind),
        .m_beacon_hops    (m_beacon_hops),
        .m_beacon_seqnum  (m_beacon_seqnum),
        .m_beacon_root    (m_beacon_root),
        .m_route_valid    (m_route_valid)
    );

    always #5ns aclk = ~aclk;

    // register copies
    logic [15:0] node_addr   = RST_LOCAL_ADDR;
    logic [15:0] bcast_addr  = RST_BCAST_ADDR;
    logic [15:0] alias_addr  = RST_ALIAS_ADDR;
    logic [7:0]  max_hops    = RST_MAX_HOPS;
    logic [30:0] valid_ticks = RST_VALID_TIME;

    // route state
    logic [15:0] root_addr      = '0;
    logic [15:0] hop_next       = '0;
    logic [15:0] seen_seqnum    = '0;
    logic [7:0]  hops_to_root   = RST_MAX_HOPS;
    logic [31:0] last_info_time = '0;
    logic        seen_in_frame  = 1'b0;

    srf_item_t   event_q[$];
    srf_result_t route_answers[$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned fail_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_used = 1'b0;
    logic        took_in = 1'b0;

    // stimulus generator state
    logic [31:0] gen_now;
    logic [15:0] gen_seq;
    logic [15:0] gen_root;

    // expires the route as a side effect once the deadline has passed
    function automatic logic route_live(logic [31:0] t);
        logic [31:0] diff;
        if (hops_to_root >= max_hops) return 1'b0;
        diff = last_info_time + {1'b0, valid_ticks} - t;
        if (diff[31]) begin
            hops_to_root = max_hops;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic srf_result_t route_step(srf_item_t it);
        srf_result_t r;
        logic        upd;
        logic        pass;
        logic [15:0] sdiff;
        logic [15:0] dst;
        logic [7:0]  hl;
        r = '0;
        r.decision = DEC_DROP;
        r.beacon_kind = BCN_NONE;
        case (action_t'(it.action))
            ACT_INFO: begin
                upd = 1'b0;
                sdiff = seen_seqnum - it.info_seqnum;
                if (!route_live(it.now) || sdiff[15]) begin
                    upd = 1'b1;
                end else if (it.info_seqnum == seen_seqnum) begin
                    if (it.info_hops < hops_to_root) upd = 1'b1;
                    else if (it.info_hops == hops_to_root && !seen_in_frame) upd = 1'b1;
                end
                if (it.info_hops > max_hops) upd = 1'b0;
                if (upd) begin
                    seen_in_frame = 1'b1;
                    root_addr = it.info_root;
                    hop_next = it.sender_addr;
                    seen_seqnum = it.info_seqnum;
                    hops_to_root = it.info_hops;
                    last_info_time = it.now;
                    r.info_updated = 1'b1;
                end
            end
            ACT_PACKET: begin
                dst = it.dst_addr;
                hl = it.hop_limit_in;
                if (it.from_self && dst == alias_addr) begin
                    dst = root_addr;
                    hl = max_hops;
                end
                if (dst == node_addr) begin
                    r.decision = DEC_LOCAL;
                end else if (dst == bcast_addr) begin
                    if (it.from_self) r.decision = DEC_BCAST;
                    else r.decision = DEC_LOCAL;
                end else begin
                    pass = 1'b1;
                    if (!it.from_self && hl != 8'd0) begin
                        hl = hl - 8'd1;
                        if (hl == 8'd0) pass = 1'b0;
                    end
                    if (!pass) begin
                        r.decision = DEC_DROP;
                    end else if (dst == root_addr) begin
                        if (route_live(it.now)) begin
                            r.next_hop = hop_next;
                            r.next_hop_known = 1'b1;
                            r.decision = DEC_UNICAST;
                        end
                    end else if (it.from_self) begin
                        r.decision = DEC_UNICAST;
                    end
                end
                r.dst_out = dst;
                r.hop_limit_out = hl;
            end
            ACT_FRAME_END: begin
                seen_in_frame = 1'b0;
            end
            default: begin
                if (hops_to_root < max_hops) begin
                    if (!route_live(it.now)) begin
                        r.beacon_kind = BCN_REQUEST;
                    end else begin
                        r.beacon_kind = BCN_INFO;
                        r.beacon_hops = hops_to_root + 8'd1;
                        r.beacon_seqnum = seen_seqnum;
                        r.beacon_root = root_addr;
                    end
                end
            end
        endcase
        r.route_valid = route_live(it.now);
        return r;
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    // sender
    always @(negedge aclk) begin
        srf_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || took_in) begin
            if (event_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = event_q.pop_front();
                s_action       <= nxt.action;
                s_now          <= nxt.now;
                s_info_seqnum  <= nxt.info_seqnum;
                s_info_hops    <= nxt.info_hops;
                s_info_root    <= nxt.info_root;
                s_sender_addr  <= nxt.sender_addr;
                s_from_self    <= nxt.from_self;
                s_dst_addr     <= nxt.dst_addr;
                s_hop_limit_in <= nxt.hop_limit_in;
                s_valid        <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off when asked
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // prediction, result check and watchdog
    always @(posedge aclk) begin
        srf_item_t   taken;
        srf_result_t want;
        took_in <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                taken.action       = s_action;
                taken.now          = s_now;
                taken.info_seqnum  = s_info_seqnum;
                taken.info_hops    = s_info_hops;
                taken.info_root    = s_info_root;
                taken.sender_addr  = s_sender_addr;
                taken.from_self    = s_from_self;
                taken.dst_addr     = s_dst_addr;
                taken.hop_limit_in = s_hop_limit_in;
                route_answers.push_back(route_step(taken));
            end
            if (m_valid && m_ready) begin
                if (route_answers.size() == 0) begin
                    $display("%0t: result word with nothing outstanding, expected none actual %0h",
                             $time, m_decision);
                    fail_cnt++;
                end else begin
                    want = route_answers.pop_front();
                    cmp_field("decision", 32'(want.decision), 32'(m_decision));
                    cmp_field("next_hop", 32'(want.next_hop), 32'(m_next_hop));
                    cmp_field("next_hop_known", 32'(want.next_hop_known),
                              32'(m_next_hop_known));
                    cmp_field("dst_out", 32'(want.dst_out), 32'(m_dst_out));
                    cmp_field("hop_limit_out", 32'(want.hop_limit_out), 32'(m_hop_limit_out));
                    cmp_field("info_updated", 32'(want.info_updated), 32'(m_info_updated));
                    cmp_field("beacon_kind", 32'(want.beacon_kind), 32'(m_beacon_kind));
                    cmp_field("beacon_hops", 32'(want.beacon_hops), 32'(m_beacon_hops));
                    cmp_field("beacon_seqnum", 32'(want.beacon_seqnum), 32'(m_beacon_seqnum));
                    cmp_field("beacon_root", 32'(want.beacon_root), 32'(m_beacon_root));
                    cmp_field("route_valid", 32'(want.route_valid), 32'(m_route_valid));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic srf_item_t ev(action_t act, logic [31:0] t, logic [15:0] seq,
                                     logic [7:0] hops, logic [15:0] root, logic [15:0] sender,
                                     logic loc, logic [15:0] dst, logic [7:0] hl);
        srf_item_t it;
        it.action       = act;
        it.now          = t;
        it.info_seqnum  = seq;
        it.info_hops    = hops;
        it.info_root    = root;
        it.sender_addr  = sender;
        it.from_self    = loc;
        it.dst_addr     = dst;
        it.hop_limit_in = hl;
        return it;
    endfunction

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_LOCAL_ADDR: node_addr = val[15:0];
            CFG_BCAST_ADDR: bcast_addr = val[15:0];
            CFG_ALIAS_ADDR: alias_addr = val[15:0];
            CFG_MAX_HOPS:   max_hops = val[7:0];
            CFG_VALID_TIME: valid_ticks = val[30:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(logic [15:0] loc, logic [15:0] bc, logic [15:0] al,
                             logic [7:0] mh, logic [30:0] vt);
        logic [31:0] r;
        set_reg(CFG_LOCAL_ADDR, 31'(loc));
        set_reg(CFG_BCAST_ADDR, 31'(bc));
        set_reg(CFG_ALIAS_ADDR, 31'(al));
        set_reg(CFG_MAX_HOPS, 31'(mh));
        set_reg(CFG_VALID_TIME, vt);
        r = $urandom;
        gen_seq = r[15:0];
        gen_root = r[31:16];
        gen_now = $urandom;
        @(posedge aclk);
    endtask

    // mostly plausible route traffic around a moving clock, with some noise
    task automatic queue_random(int n);
        srf_item_t   it;
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        int unsigned pick;
        for (int k = 0; k < n; k++) begin
            r0 = $urandom;
            r1 = $urandom;
            r2 = $urandom;
            it.info_seqnum  = r0[15:0];
            it.info_hops    = r0[23:16];
            it.hop_limit_in = r0[31:24];
            it.info_root    = r1[15:0];
            it.sender_addr  = r1[31:16];
            it.dst_addr     = r2[15:0];
            it.from_self    = r2[16];
            case ($urandom_range(15))
                0: gen_now = $urandom;
                1: gen_now = gen_now + {1'b0, valid_ticks} + $urandom_range(2);
                default: gen_now = gen_now + ($urandom % ({1'b0, valid_ticks} / 8 + 1));
            endcase
            it.now = gen_now;
            pick = $urandom_range(99);
            if (pick < 35) begin
                it.action = ACT_INFO;
                pick = $urandom_range(9);
                if (pick < 5) begin
                    it.info_seqnum = gen_seq;
                end else if (pick < 8) begin
                    gen_seq = gen_seq + 16'd1;
                    it.info_seqnum = gen_seq;
                end else if (pick < 9) begin
                    it.info_seqnum = gen_seq - 16'($urandom_range(1, 3));
                end
                if ($urandom_range(9) < 8) it.info_hops = 8'($urandom_range(max_hops));
                if ($urandom_range(19) == 0) gen_root = r2[31:16];
                if ($urandom_range(9) != 0) it.info_root = gen_root;
            end else if (pick < 75) begin
                it.action = ACT_PACKET;
                pick = $urandom_range(9);
                if (pick < 3) it.dst_addr = alias_addr;
                else if (pick < 5) it.dst_addr = gen_root;
                else if (pick < 6) it.dst_addr = node_addr;
                else if (pick < 7) it.dst_addr = bcast_addr;
                pick = $urandom_range(7);
                if (pick < 3) it.hop_limit_in = 8'(pick);
            end else if (pick < 85) begin
                it.action = ACT_FRAME_END;
            end else begin
                it.action = ACT_BEACON;
            end
            event_q.push_back(it);
        end
    endtask

    task automatic drain();
        while (event_q.size() != 0 || s_valid || route_answers.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] r;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 14;
        sink_idle_pct = 86;
        // nothing to advertise and no route for the root alias
        event_q.push_back(ev(ACT_BEACON, 32'd10, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0, 16'd0, 8'd0));
        event_q.push_back(ev(ACT_PACKET, 32'd20, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1,
                             RST_ALIAS_ADDR, 8'd0));
        // first info, then same hops in the same frame, then after frame end
        event_q.push_back(ev(ACT_INFO, 32'd100, 16'd5, 8'd2, 16'h1234, 16'h0042, 1'b0,
                             16'd0, 8'd0));
        event_q.push_back(ev(ACT_INFO, 32'd110, 16'd5, 8'd2, 16'h1234, 16'h0043, 1'b0,
                             16'd0, 8'd0));
        event_q.push_back(ev(ACT_FRAME_END, 32'd120, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0,
                             16'd0, 8'd0));
        event_q.push_back(ev(ACT_INFO, 32'd130, 16'd5, 8'd2, 16'h1234, 16'h0043, 1'b0,
                             16'd0, 8'd0));
        event_q.push_back(ev(ACT_INFO, 32'd140, 16'd5, 8'd1, 16'h1234, 16'h0044, 1'b0,
                             16'd0, 8'd0));
        // older sequence number, then one half the serial space ahead
        event_q.push_back(ev(ACT_INFO, 32'd150, 16'd4, 8'd0, 16'h1234, 16'h0045, 1'b0,
                             16'd0, 8'd0));
        event_q.push_back(ev(ACT_INFO, 32'd160, 16'h8005, 8'd3, 16'h1234, 16'h0046, 1'b0,
                             16'd0, 8'd0));
        // hop count above the maximum, then exactly at it
        event_q.push_back(ev(ACT_INFO, 32'd170, 16'h8006, RST_MAX_HOPS + 8'd1, 16'h1234,
                             16'h0047, 1'b0, 16'd0, 8'd0));
        event_q.push_back(ev(ACT_INFO, 32'd180, 16'h8006, RST_MAX_HOPS, 16'h1234, 16'h0048,
                             1'b0, 16'd0, 8'd0));
        event_q.push_back(ev(ACT_INFO, 32'd200, 16'h8007, 8'd0, 16'h1234, 16'hFFFF, 1'b0,
                             16'd0, 8'd0));
        event_q.push_back(ev(ACT_BEACON, 32'd300, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0, 16'd0, 8'd0));
        // root alias, hop limit edges, local, broadcast, unknown next hop
        event_q.push_back(ev(ACT_PACKET, 32'd310, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1,
                             RST_ALIAS_ADDR, 8'd7));
        event_q.push_back(ev(ACT_PACKET, 32'd320, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0, 16'h1234, 8'd1));
        event_q.push_back(ev(ACT_PACKET, 32'd330, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0, 16'h1234, 8'd0));
        event_q.push_back(ev(ACT_PACKET, 32'd340, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0, 16'h1234,
                             8'd255));
        event_q.push_back(ev(ACT_PACKET, 32'd350, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0,
                             RST_LOCAL_ADDR, 8'd0));
        event_q.push_back(ev(ACT_PACKET, 32'd360, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1,
                             RST_BCAST_ADDR, 8'd0));
        event_q.push_back(ev(ACT_PACKET, 32'd370, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0,
                             RST_BCAST_ADDR, 8'd4));
        event_q.push_back(ev(ACT_PACKET, 32'd380, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1, 16'h5555, 8'd9));
        event_q.push_back(ev(ACT_PACKET, 32'd390, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0,
                             RST_ALIAS_ADDR, 8'd3));
        // right at the deadline, then one tick past it
        event_q.push_back(ev(ACT_BEACON, 32'd200 + 32'(RST_VALID_TIME), 16'd0, 8'd0, 16'd0,
                             16'd0, 1'b0, 16'd0, 8'd0));
        event_q.push_back(ev(ACT_BEACON, 32'd201 + 32'(RST_VALID_TIME), 16'd0, 8'd0, 16'd0,
                             16'd0, 1'b0, 16'd0, 8'd0));
        // route learned just before the clock wraps, used just after
        event_q.push_back(ev(ACT_INFO, 32'hFFFF_FFF0, 16'h8008, 8'd4, 16'hABCD, 16'h0001, 1'b0,
                             16'd0, 8'd0));
        event_q.push_back(ev(ACT_PACKET, 32'h0000_0010, 16'd0, 8'd0, 16'd0, 16'd0, 1'b1,
                             RST_ALIAS_ADDR, 8'd0));
        drain();

        configure(16'h0000, 16'hFFFF, 16'h0001, 8'd255, 31'h7FFF_FFFF);
        queue_random(400);
        drain();

        src_idle_pct = 86;
        sink_idle_pct = 14;
        configure(16'hFFFF, 16'h0000, 16'h8000, 8'd1, 31'd1);
        queue_random(400);
        drain();

        r = $urandom;
        configure(r[15:0], r[31:16], 16'($urandom), 8'd16, 31'd200);
        queue_random(400);
        drain();

        // no idling; the receiver holds off once so the input backs up
        src_idle_pct = 0;
        sink_idle_pct = 0;
        r = $urandom;
        configure(r[15:0], r[31:16], 16'($urandom), 8'($urandom_range(2, 64)),
                  31'($urandom_range(1, 5000)));
        queue_random(450);
        @(posedge aclk);
        hold_req = 1'b1;
        drain();

        repeat (5) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
